// ===== hw/rtl/pmmcg_pkg.sv =====
// pmmcg_pkg: shared types and constants for the prime modulus MCG block.
// No dependencies. Used by controller, datapath and top level.
package pmmcg_pkg;

   localparam int WORD_W      = 64;
   localparam int SEED_HIGH_W = 63;
   localparam int LIMB_W      = 32;
   localparam int ACC_W       = 192;
   localparam int SUM_W       = 129;
   localparam int FOLD_W      = 8;
   localparam int FPROD_W     = WORD_W + FOLD_W;
   localparam int SEL_W       = 3;
   localparam int SHIFT_W     = 3;

   // m = 2^128 - 159, folded as 159*H + L
   localparam logic [FOLD_W-1:0] MOD_FOLD      = 8'd159;
   localparam logic [WORD_W-1:0] MOD_LOW_LIMIT = 64'hFFFF_FFFF_FFFF_FF61;
   localparam logic [WORD_W-1:0] MULT_RESET    = 64'd17914599225194756760;
   localparam logic [SEL_W-1:0]  SEL_LAST      = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_FOLD,
      ST_REDUCE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic             load_seed;
      logic             clear_acc;
      logic             mul_issue;
      logic [SEL_W-1:0] mul_sel;
      logic             acc_add;
      logic             fold;
      logic             reduce;
      logic             out_low;
      logic             out_high;
   } cmd_type;

endpackage

// ===== hw/rtl/pmmcg_datapath.sv =====
// pmmcg_datapath: state, multiplier register, 32x32 partial product unit,
// 192-bit accumulator, fold and final reduction. Depends on pmmcg_pkg.
module pmmcg_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pmmcg_pkg::cmd_type                   cmd,
   input  logic                                 csr_write,
   input  logic [pmmcg_pkg::WORD_W-1:0]         csr_multiplier,
   input  logic [pmmcg_pkg::WORD_W-1:0]         req_seed_low,
   input  logic [pmmcg_pkg::SEED_HIGH_W-1:0]    req_seed_high,
   output logic [pmmcg_pkg::WORD_W-1:0]         rsp_random_word
);
   import pmmcg_pkg::*;

   logic [WORD_W-1:0]     mult_ff, mult_in;
   logic [WORD_W-1:0]     state_low_ff, state_low_in;
   logic [WORD_W-1:0]     state_high_ff, state_high_in;
   logic [2*LIMB_W-1:0]   prod_ff, prod_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [LIMB_W-1:0]     a_limb, x_limb;
   logic [ACC_W-1:0]      addend;
   logic [FPROD_W-1:0]    fold_prod;
   logic                  ge_mod;
   logic [2*WORD_W-1:0]   reduced;

   always_comb begin
      a_limb = cmd.mul_sel[0] ? mult_ff[WORD_W-1:LIMB_W] : mult_ff[LIMB_W-1:0];
      case (cmd.mul_sel[2:1])
         2'd0:    x_limb = state_low_ff[LIMB_W-1:0];
         2'd1:    x_limb = state_low_ff[WORD_W-1:LIMB_W];
         2'd2:    x_limb = state_high_ff[LIMB_W-1:0];
         2'd3:    x_limb = state_high_ff[WORD_W-1:LIMB_W];
         default: x_limb = '0;
      endcase
   end

   assign prod_in  = a_limb * x_limb;
   assign shift_in = {2'b00, cmd.mul_sel[0]} + {1'b0, cmd.mul_sel[2:1]};

   always_comb begin
      case (shift_ff)
         3'd0:    addend = {128'b0, prod_ff};
         3'd1:    addend = {96'b0, prod_ff, 32'b0};
         3'd2:    addend = {64'b0, prod_ff, 64'b0};
         3'd3:    addend = {32'b0, prod_ff, 96'b0};
         3'd4:    addend = {prod_ff, 128'b0};
         default: addend = '0;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear_acc) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + addend;
      end
   end

   assign fold_prod = acc_ff[ACC_W-1:2*WORD_W] * MOD_FOLD;
   assign sum_in    = {1'b0, acc_ff[2*WORD_W-1:0]}
                      + {{(SUM_W-FPROD_W){1'b0}}, fold_prod};

   // s >= m: subtracting m is adding 159 mod 2^128
   assign ge_mod  = sum_ff[SUM_W-1]
                    || ((&sum_ff[2*WORD_W-1:WORD_W]) && (sum_ff[WORD_W-1:0] >= MOD_LOW_LIMIT));
   assign reduced = ge_mod ? sum_ff[2*WORD_W-1:0] + {{(2*WORD_W-FOLD_W){1'b0}}, MOD_FOLD}
                           : sum_ff[2*WORD_W-1:0];

   always_comb begin
      mult_in       = csr_write ? csr_multiplier : mult_ff;
      state_low_in  = state_low_ff;
      state_high_in = state_high_ff;
      if (cmd.load_seed) begin
         state_low_in  = req_seed_low | {{(WORD_W-1){1'b0}}, 1'b1};
         state_high_in = {1'b0, req_seed_high};
      end else if (cmd.reduce) begin
         state_low_in  = reduced[WORD_W-1:0];
         state_high_in = reduced[2*WORD_W-1:WORD_W];
      end
      word_in = word_ff;
      if (cmd.out_low) begin
         word_in = state_low_ff;
      end else if (cmd.out_high) begin
         word_in = state_high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff       <= MULT_RESET;
         state_low_ff  <= {{(WORD_W-1){1'b0}}, 1'b1};
         state_high_ff <= '0;
      end else begin
         mult_ff       <= mult_in;
         state_low_ff  <= state_low_in;
         state_high_ff <= state_high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_issue) begin
         prod_ff  <= prod_in;
         shift_ff <= shift_in;
      end
      if (cmd.fold) begin
         sum_ff <= sum_in;
      end
      acc_ff  <= acc_in;
      word_ff <= word_in;
   end

   assign rsp_random_word = word_ff;

endmodule

// ===== hw/rtl/pmmcg_controller.sv =====
// pmmcg_controller: sequencer for draws and seed loads, phase bit and
// result valid flag. Depends on pmmcg_pkg.
module pmmcg_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_mode,
   input  logic               rsp_stall,
   output logic               req_stall,
   output logic               rsp_valid,
   output pmmcg_pkg::cmd_type cmd
);
   import pmmcg_pkg::*;

   state_type         state_ff, state_in;
   logic [SEL_W-1:0]  cnt_ff, cnt_in;
   logic              low_phase_ff, low_phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;
   logic              accept;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (!req_mode && !low_phase_ff && !slot_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      low_phase_in = low_phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  cmd.load_seed = 1'b1;
                  low_phase_in  = 1'b1;
               end else if (low_phase_ff) begin
                  cmd.clear_acc = 1'b1;
                  cnt_in        = '0;
                  low_phase_in  = 1'b0;
                  state_in      = ST_MUL;
               end else begin
                  cmd.out_high  = 1'b1;
                  rsp_valid_in  = 1'b1;
                  low_phase_in  = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_issue = 1'b1;
            cmd.acc_add   = (cnt_ff != '0);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == SEL_LAST) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (slot_free) begin
               cmd.out_low  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         low_phase_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         low_phase_ff <= low_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/prime_modulus_mcg128_generator.sv =====
// An advancing draw goes from accept through MUL (shared 32x32 multiplier),
// ACC, FOLD, REDUCE and DELIVER, which waits for a free response slot; no
// request is taken before it is delivered. Alternate draws and seed loads are
// taken one beat per cycle, an alternate draw only while the slot is free.
// Synchronous active-high reset: state = 1, multiplier = default, low phase.
// Depends on pmmcg_pkg, pmmcg_controller, pmmcg_datapath.
module prime_modulus_mcg128_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [pmmcg_pkg::WORD_W-1:0]      req_seed_low,
   input  logic [pmmcg_pkg::SEED_HIGH_W-1:0] req_seed_high,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pmmcg_pkg::WORD_W-1:0]      rsp_random_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmmcg_pkg::WORD_W-1:0]      csr_multiplier
);
   import pmmcg_pkg::*;

   cmd_type cmd;
   logic    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   pmmcg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   pmmcg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_write       (csr_write),
      .csr_multiplier  (csr_multiplier),
      .req_seed_low    (req_seed_low),
      .req_seed_high   (req_seed_high),
      .rsp_random_word (rsp_random_word)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for prime_modulus_mcg128_generator (a*x mod 2^128-159).
// Directed table then random seed/draw phases, checked against an in-bench MCG model.
// Depends on pmmcg_pkg and the generator RTL.
module tb_top;
   import pmmcg_pkg::*;

   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_SEED = 1'b1;
   localparam logic [128:0] MODULUS = (129'd1 << 128) - 129'd159;
   localparam logic [WORD_W-1:0] MULT_ALT_A = 64'd17739802050595713108;
   localparam logic [WORD_W-1:0] MULT_ALT_B = 64'd18250064560775652398;
   localparam logic [WORD_W-1:0] ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [SEED_HIGH_W-1:0] ONES_63 = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam int DIR_ROWS = 25;
   localparam int ITEM_TARGET = 1075;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                   wr_mult;
      logic [WORD_W-1:0]      mult;
      logic                   mode;
      logic [WORD_W-1:0]      seed_low;
      logic [SEED_HIGH_W-1:0] seed_high;
      logic                   typed;
      logic [WORD_W-1:0]      word;
   } dir_row_type;

   // typed words: a*1 = a, multiplier 1 returns the seed, multiplier 0 collapses to 0
   dir_row_type dir_table [DIR_ROWS] = '{
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, MULT_RESET},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_SEED, ONES_64, ONES_63, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_SEED, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, MULT_RESET},
      '{1'b0, 64'd0, MODE_SEED, 64'h0123_4567_89AB_CDEE, 63'h5555_5555_5555_5555,
        1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b1, 64'd1, MODE_SEED, 64'hDEAD_BEEF_0BAD_F00C, 63'h2AAA_AAAA_AAAA_AAAA,
        1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'hDEAD_BEEF_0BAD_F00D},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'h2AAA_AAAA_AAAA_AAAA},
      '{1'b0, 64'd0, MODE_SEED, ONES_64, ONES_63, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, ONES_64},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
      '{1'b1, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'd0},
      '{1'b1, ONES_64, MODE_SEED, 64'd0, 63'd0, 1'b0, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, ONES_64},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b1, 64'd0},
      '{1'b0, 64'd0, MODE_DRAW, 64'd0, 63'd0, 1'b0, 64'd0}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_DRAW;
   logic [WORD_W-1:0]      req_seed_low = '0;
   logic [SEED_HIGH_W-1:0] req_seed_high = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WORD_W-1:0]      rsp_random_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [WORD_W-1:0]      csr_multiplier = '0;

   logic [127:0]      mcg_x = 128'd1;
   logic [WORD_W-1:0] mcg_mult = MULT_RESET;
   logic              low_next = 1'b1;
   logic [WORD_W-1:0] words_due [$];

   bit no_gaps = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int seeds_sent = 0;
   int words_checked = 0;
   int mult_writes = 0;
   int mismatches = 0;

   prime_modulus_mcg128_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_seed_low    (req_seed_low),
      .req_seed_high   (req_seed_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_multiplier  (csr_multiplier)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [127:0] mcg_advance(logic [127:0] x, logic [WORD_W-1:0] a);
      logic [191:0] prod;
      logic [128:0] fold_sum;
      prod = {128'd0, a} * {64'd0, x};
      fold_sum = {1'b0, prod[127:0]} + {65'd0, prod[191:128]} * 129'd159;
      if (fold_sum >= MODULUS) fold_sum = fold_sum - MODULUS;
      return fold_sum[127:0];
   endfunction

   task automatic mcg_step(input logic mode, input logic [WORD_W-1:0] sl,
                           input logic [SEED_HIGH_W-1:0] sh,
                           output bit gives_word, output logic [WORD_W-1:0] word);
      if (mode == MODE_SEED) begin
         mcg_x = {1'b0, sh, sl | 64'd1};
         low_next = 1'b1;
         gives_word = 1'b0;
         word = '0;
      end else if (low_next) begin
         mcg_x = mcg_advance(mcg_x, mcg_mult);
         low_next = 1'b0;
         gives_word = 1'b1;
         word = mcg_x[63:0];
      end else begin
         low_next = 1'b1;
         gives_word = 1'b1;
         word = mcg_x[127:64];
      end
   endtask

   // called at a clock edge; returns at the edge that accepts the beat
   task automatic send_beat(input logic mode, input logic [WORD_W-1:0] sl,
                            input logic [SEED_HIGH_W-1:0] sh,
                            input logic typed, input logic [WORD_W-1:0] want);
      int gap;
      bit gives_word;
      logic [WORD_W-1:0] word;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_seed_low  <= sl;
      req_seed_high <= sh;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (mode == MODE_SEED) seeds_sent++;
      mcg_step(mode, sl, sh, gives_word, word);
      if (gives_word) words_due.push_back(typed ? want : word);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_multiplier(input logic [WORD_W-1:0] value);
      drain_words();
      csr_valid      <= 1'b1;
      csr_multiplier <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mcg_mult = value;
      mult_writes++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("unexpected word %h", rsp_random_word);
               mismatches++;
            end else begin
               if (rsp_random_word !== words_due[0]) begin
                  if (mismatches < MAX_REPORTS)
                     $display("word %0d mismatch: expected %h, got %h",
                              words_checked, words_due[0], rsp_random_word);
                  mismatches++;
               end
               void'(words_due.pop_front());
               words_checked++;
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (rsp_valid && stall_left != 0) stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, words_due.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      int phase_len;
      int j;
      logic [WORD_W-1:0] new_mult;
      logic item_mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_table[i].wr_mult) write_multiplier(dir_table[i].mult);
         send_beat(dir_table[i].mode, dir_table[i].seed_low, dir_table[i].seed_high,
                   dir_table[i].typed, dir_table[i].word);
      end

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1:    new_mult = MULT_RESET;
            2:       new_mult = MULT_ALT_A;
            3:       new_mult = MULT_ALT_B;
            4:       new_mult = 64'd1;
            5:       new_mult = ONES_64;
            6:       new_mult = 64'd0;
            default: new_mult = {$urandom, $urandom};
         endcase
         write_multiplier(new_mult);
         no_gaps = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 160);
         send_beat(MODE_SEED, {$urandom, $urandom}, 63'({$urandom, $urandom}), 1'b0, '0);
         for (j = 1; j < phase_len && items_sent < ITEM_TARGET; j++) begin
            if ($urandom_range(0, 63) == 0) drain_words();
            item_mode = ($urandom_range(0, 4) == 0) ? MODE_SEED : MODE_DRAW;
            send_beat(item_mode, {$urandom, $urandom}, 63'({$urandom, $urandom}),
                      1'b0, '0);
         end
      end
      drain_words();

      $display("tb_top: %0d request beats (%0d seed loads), %0d words compared",
               items_sent, seeds_sent, words_checked);
      $display("tb_top: %0d multiplier writes, %0d mismatches", mult_writes, mismatches);
      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pmmcg_pkg.sv
hw/rtl/pmmcg_datapath.sv
hw/rtl/pmmcg_controller.sv
hw/rtl/prime_modulus_mcg128_generator.sv
tb/sv/tb_top.sv
